// ----- rtl/mdpc_pkg.sv -----
// Shared constants, state encoding and control structures of the modular dot product checker.
package mdpc_pkg;

  // Field widths of the transactions
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned CLAIM_W = 64;
  localparam int unsigned MOD_W   = 31;

  // Remainder unit: magnitudes up to 65 bits, one quotient bit per step
  localparam int unsigned MAG_W     = CLAIM_W + 1;
  localparam int unsigned RED_STEPS = MAG_W;
  localparam int unsigned CNT_W     = $clog2(RED_STEPS);

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned IDX_W   = PADDR_W - 2;
  localparam logic [IDX_W-1:0] IDX_MODULUS = '0;
  localparam logic [MOD_W-1:0] MODULUS_RESET = {MOD_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ABS,
    ST_RED,
    ST_FIX,
    ST_CLAIM,
    ST_CRED,
    ST_CFIX
  } mdpc_state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic sum;
    logic abs_load;
    logic claim_load;
    logic red_step;
    logic fix_elem;
    logic out_load;
  } mdpc_cmd_t;

  typedef struct packed {
    logic last;
    logic red_done;
  } mdpc_status_t;

endpackage

// ----- rtl/mdpc_in_if.sv -----
// Input channel: one element pair with claimed sum and last flag per transaction.
interface mdpc_in_if import mdpc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [ELEM_W-1:0]  elem_a;
  logic signed [ELEM_W-1:0]  elem_b;
  logic signed [CLAIM_W-1:0] claimed_sum;
  logic                      last_elem;

  modport source (output valid, elem_a, elem_b, claimed_sum, last_elem, input ready);
  modport sink (input valid, elem_a, elem_b, claimed_sum, last_elem, output ready);
endinterface

// ----- rtl/mdpc_out_if.sv -----
// Output channel: congruence flag and residue per transaction.
interface mdpc_out_if import mdpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             congruent;
  logic [MOD_W-1:0] residue;

  modport source (output valid, congruent, residue, input ready);
  modport sink (input valid, congruent, residue, output ready);
endinterface

// ----- rtl/modular_dot_product_check_core.sv -----
// The block takes one element at a time: an element without the last flag keeps it busy
// through multiply, sum, remainder and fix-up; a last element also runs the claimed sum
// through the remainder unit and waits for a free output slot before the next is taken.
// Rate is set by the shared 65-step remainder unit, one bit per cycle, run once per element
// and once more for the claimed sum. Reset is asynchronous and active low: running residue
// to zero, modulus to 2^31-1, output empty; no clearing pass.
module modular_dot_product_check_core import mdpc_pkg::*; #(
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mdpc_in_if.sink            in_i,
  mdpc_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [MOD_W-1:0] modulus_q;
  logic [IDX_W-1:0] reg_idx;
  logic             wr_modulus;
  mdpc_cmd_t        cmd;
  mdpc_status_t     status;

  // Register file decode
  assign reg_idx    = paddr[PADDR_W-1:2];
  assign wr_modulus = psel && penable && pwrite && (reg_idx == IDX_MODULUS);
  assign pready     = 1'b1;
  assign prdata     = (reg_idx == IDX_MODULUS) ? PDATA_W'(modulus_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
    end else if (wr_modulus) begin
      modulus_q <= pwdata[MOD_W-1:0];
    end
  end

  mdpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mdpc_datapath #(
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .elem_a_i      (in_i.elem_a),
    .elem_b_i      (in_i.elem_b),
    .claimed_sum_i (in_i.claimed_sum),
    .last_elem_i   (in_i.last_elem),
    .modulus_i     (modulus_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .congruent_o   (out_o.congruent),
    .residue_o     (out_o.residue)
  );

endmodule

// ----- rtl/mdpc_ctrl.sv -----
// Sequencing state machine and output valid flag of the checker.
module mdpc_ctrl import mdpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  mdpc_status_t status_i,
  output mdpc_cmd_t    cmd_o
);

  mdpc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Hold state and output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance through multiply, sum, remainder and claim check
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.abs_load = 1'b1;
        state_d        = ST_RED;
      end
      ST_RED: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.fix_elem = 1'b1;
        state_d        = status_i.last ? ST_CLAIM : ST_IDLE;
      end
      ST_CLAIM: begin
        cmd_o.claim_load = 1'b1;
        state_d          = ST_CRED;
      end
      ST_CRED: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_done) begin
          state_d = ST_CFIX;
        end
      end
      ST_CFIX: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Set on load, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/mdpc_datapath.sv -----
// Multiplier, signed accumulate, bit-serial remainder unit and result register.
module mdpc_datapath import mdpc_pkg::*; #(
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [ELEM_W-1:0]  elem_a_i,
  input  logic signed [ELEM_W-1:0]  elem_b_i,
  input  logic signed [CLAIM_W-1:0] claimed_sum_i,
  input  logic                      last_elem_i,
  input  logic [MOD_W-1:0]          modulus_i,
  input  mdpc_cmd_t                 cmd_i,
  output mdpc_status_t              status_o,
  output logic                      congruent_o,
  output logic [MOD_W-1:0]          residue_o
);

  localparam int unsigned PROD_W = 2 * ELEM_BITS;
  localparam int unsigned SUM_W  = MAG_W + 1;

  // Captured transaction
  logic [ELEM_BITS-1:0] a_q, b_q;
  logic [CLAIM_W-1:0]   claim_q;
  logic                 last_q;

  // Pipeline and remainder state
  logic [PROD_W-1:0]  prod_q;
  logic               pneg_q;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [MAG_W-1:0]   shift_q;
  logic [MOD_W-1:0]   rem_q, rem_d;
  logic               rneg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [MOD_W-1:0]   running_q;
  logic               congruent_q;
  logic [MOD_W-1:0]   residue_q;

  logic [ELEM_BITS-1:0] mag_a, mag_b;
  logic [SUM_W-1:0]     sum_abs;
  logic [CLAIM_W-1:0]   claim_mag;
  logic [MOD_W:0]       m_eff, trial, trial_diff, fix_diff;
  logic [MOD_W-1:0]     fixed;

  // Decode elements into magnitude and sign
  assign mag_a = a_q[ELEM_BITS-1] ? (~a_q + 1'b1) : a_q;
  assign mag_b = b_q[ELEM_BITS-1] ? (~b_q + 1'b1) : b_q;

  // Running residue plus or minus the product, as a signed value
  always_comb begin
    if (pneg_q) begin
      sum_d = SUM_W'(running_q) - SUM_W'(prod_q);
    end else begin
      sum_d = SUM_W'(running_q) + SUM_W'(prod_q);
    end
  end

  assign sum_abs   = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign claim_mag = claim_q[CLAIM_W-1] ? (~claim_q + 1'b1) : claim_q;

  // Register value zero stands for 2^31
  assign m_eff = (modulus_i == '0) ? {1'b1, {MOD_W{1'b0}}} : {1'b0, modulus_i};

  // One restoring step: bring down a bit, subtract the modulus if it fits
  assign trial      = {rem_q, shift_q[MAG_W-1]};
  assign trial_diff = trial - m_eff;
  assign rem_d      = (trial >= m_eff) ? trial_diff[MOD_W-1:0] : trial[MOD_W-1:0];

  // Map a negative value's remainder onto the non-negative representative
  assign fix_diff = m_eff - {1'b0, rem_q};
  assign fixed    = (rneg_q && rem_q != '0) ? fix_diff[MOD_W-1:0] : rem_q;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q     <= elem_a_i[ELEM_BITS-1:0];
      b_q     <= elem_b_i[ELEM_BITS-1:0];
      claim_q <= claimed_sum_i;
      last_q  <= last_elem_i;
    end
    if (cmd_i.mul) begin
      prod_q <= mag_a * mag_b;
      pneg_q <= a_q[ELEM_BITS-1] ^ b_q[ELEM_BITS-1];
    end
    if (cmd_i.sum) begin
      sum_q <= sum_d;
    end
    if (cmd_i.abs_load) begin
      shift_q <= sum_abs[MAG_W-1:0];
      rneg_q  <= sum_q[SUM_W-1];
      rem_q   <= '0;
    end else if (cmd_i.claim_load) begin
      shift_q <= MAG_W'(claim_mag);
      rneg_q  <= claim_q[CLAIM_W-1];
      rem_q   <= '0;
    end else if (cmd_i.red_step) begin
      shift_q <= {shift_q[MAG_W-2:0], 1'b0};
      rem_q   <= rem_d;
    end
    if (cmd_i.out_load) begin
      congruent_q <= (fixed == running_q);
      residue_q   <= running_q;
    end
  end

  // Step counter and running residue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      running_q <= '0;
    end else begin
      if (cmd_i.abs_load || cmd_i.claim_load) begin
        cnt_q <= '0;
      end else if (cmd_i.red_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.fix_elem) begin
        running_q <= fixed;
      end else if (cmd_i.out_load) begin
        running_q <= '0;
      end
    end
  end

  assign status_o.last     = last_q;
  assign status_o.red_done = (cnt_q == CNT_W'(RED_STEPS - 1));
  assign congruent_o       = congruent_q;
  assign residue_o         = residue_q;

endmodule

// ----- rtl/mdpc_checker.sv -----
// Port-level assertions of the checker core and their bind to the top level.
module mdpc_checker import mdpc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               congruent_i,
  input logic [MOD_W-1:0]   residue_i,
  input logic [PADDR_W-1:0] paddr_i,
  input logic [PDATA_W-1:0] prdata_i
);

  // One element at a time: busy right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an element is in work");

  // A result only appears at the end of work, never straight from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised without an element in work");

  // Residue stays below the programmed modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (paddr_i[PADDR_W-1:2] == IDX_MODULUS) && (prdata_i[MOD_W-1:0] != '0)
    |-> residue_i < prdata_i[MOD_W-1:0])
    else $error("residue not reduced below the modulus");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(residue_i) && $stable(congruent_i))
    else $error("stalled result changed");

endmodule

bind modular_dot_product_check_core mdpc_checker u_mdpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .congruent_i (out_o.congruent),
  .residue_i   (out_o.residue),
  .paddr_i     (paddr),
  .prdata_i    (prdata)
);

// ----- tb/tb_modular_dot_product_check_core.sv -----
`timescale 1ns / 1ps
// Testbench of the modular dot product checker: predicted verdicts, random flow control.
module tb_modular_dot_product_check_core;
  import mdpc_pkg::*;

  localparam logic [PADDR_W-1:0] MODULUS_ADDR = {IDX_MODULUS, 2'b00};
  localparam logic [ELEM_W-1:0]  ELEM_MIN     = 32'h8000_0000;
  localparam logic [ELEM_W-1:0]  ELEM_MAX     = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0]  ELEM_NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [CLAIM_W-1:0] CLAIM_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [CLAIM_W-1:0] CLAIM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 600;
  localparam int STALL_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 50;

  typedef struct packed {
    logic             congruent;
    logic [MOD_W-1:0] residue;
  } verdict_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mdpc_in_if  in_if ();
  mdpc_out_if out_if ();

  // Predictor state and expected verdicts
  logic [MOD_W-1:0] modulus_shadow;
  logic [63:0]      partial_residue;
  verdict_t         verdict_q[$];

  int  mismatch_count;
  int  idle_cycles;
  int  hold_left;
  bit  hold_off_start;
  bit  steady_flow;

  modular_dot_product_check_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Free-running clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Register value zero stands for 2^31
  function automatic logic [63:0] active_modulus();
    return (modulus_shadow == '0) ? 64'h8000_0000 : {33'd0, modulus_shadow};
  endfunction

  function automatic logic [63:0] elem_magnitude(input logic [ELEM_W-1:0] v);
    logic [ELEM_W-1:0] mag;
    mag = v[ELEM_W-1] ? (~v + 32'd1) : v;
    return {32'd0, mag};
  endfunction

  // Non-negative representative of a signed magnitude
  function automatic logic [63:0] wrap_signed(input logic [63:0] mag, input logic neg,
                                              input logic [63:0] m);
    logic [63:0] r;
    r = mag % m;
    if (neg && r != 0) begin
      r = m - r;
    end
    return r;
  endfunction

  function automatic logic [63:0] residue_after_pair(input logic [ELEM_W-1:0] a,
                                                     input logic [ELEM_W-1:0] b);
    logic [63:0] m;
    logic [63:0] prod;
    m = active_modulus();
    prod = elem_magnitude(a) * elem_magnitude(b);
    return ((partial_residue % m) + wrap_signed(prod, a[ELEM_W-1] ^ b[ELEM_W-1], m)) % m;
  endfunction

  function automatic logic [63:0] claim_residue(input logic [CLAIM_W-1:0] claim);
    logic [63:0] mag;
    mag = claim[CLAIM_W-1] ? (~claim + 64'd1) : claim;
    return wrap_signed(mag, claim[CLAIM_W-1], active_modulus());
  endfunction

  // Residue plus a random multiple of the modulus, kept inside 64-bit signed range
  function automatic logic [CLAIM_W-1:0] congruent_claim(input logic [63:0] residue);
    longint m;
    longint span;
    longint k;
    m = longint'(active_modulus());
    span = longint'(64'h7FFF_FFFF_7FFF_FFFF) / m;
    k = longint'({$urandom, $urandom}) % (span + 1);
    return CLAIM_W'(longint'(residue) + k * m);
  endfunction

  function automatic logic [CLAIM_W-1:0] pick_claim(input logic [63:0] residue);
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      return congruent_claim(residue);
    end else if (pick < 80) begin
      return congruent_claim(residue) + CLAIM_W'($urandom_range(3, 1));
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      3: return $urandom_range(1) ? ELEM_NEG_ONE : 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one element pair, wait for its transaction, update the prediction
  task automatic send_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                           input logic [CLAIM_W-1:0] claim, input logic last);
    int gap;
    logic [63:0] sum;
    gap = 0;
    if (!steady_flow) begin
      if ($urandom_range(99) < 4) begin
        gap = $urandom_range(150, 1);
      end else begin
        while ($urandom_range(99) < 36) gap++;
      end
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.elem_a      <= a;
    in_if.elem_b      <= b;
    in_if.claimed_sum <= claim;
    in_if.last_elem   <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sum = residue_after_pair(a, b);
    if (last) begin
      verdict_q.push_back('{congruent: (claim_residue(claim) == sum),
                            residue: sum[MOD_W-1:0]});
      partial_residue = '0;
    end else begin
      partial_residue = sum;
    end
    @(negedge clk_i);
  endtask

  // Single-element vector with a congruent claim
  task automatic send_single(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
    send_pair(a, b, congruent_claim(residue_after_pair(a, b)), 1'b1);
  endtask

  // Drain every expected verdict, then let the block settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Setup and access phase on the register port; called at a falling edge
  task automatic write_modulus(input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODULUS_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    modulus_shadow = value[MOD_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Field extremes under the reset modulus
  task automatic test_extremes();
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    send_single(ELEM_MIN, ELEM_MIN);
    send_pair(ELEM_MAX, ELEM_MIN, CLAIM_MIN, 1'b1);
    send_pair(ELEM_MAX, ELEM_MAX, CLAIM_MAX, 1'b1);
    send_pair('0, '0, '0, 1'b1);
    send_pair(ELEM_NEG_ONE, 32'd1, {CLAIM_W{1'b1}}, 1'b1);
    // three-element vector with a claim off by one
    send_pair(ELEM_MIN, ELEM_MAX, CLAIM_MAX, 1'b0);
    send_pair(ELEM_NEG_ONE, ELEM_NEG_ONE, CLAIM_MIN, 1'b0);
    a = 32'd12345;
    b = -32'sd6789;
    send_pair(a, b, congruent_claim(residue_after_pair(a, b)) + 64'd1, 1'b1);
  endtask

  // Register value zero acts as modulus 2^31
  task automatic test_modulus_zero();
    wait_idle();
    write_modulus('0);
    send_pair(ELEM_MIN, ELEM_MIN, 64'h4000_0000_0000_0000, 1'b1);
    send_pair(ELEM_MIN, 32'd1, 64'hFFFF_FFFF_8000_0000, 1'b1);
    send_pair(ELEM_NEG_ONE, ELEM_MAX, CLAIM_MIN, 1'b1);
  endtask

  // Modulus one, with the unused top data bit set
  task automatic test_modulus_one();
    wait_idle();
    write_modulus(32'h8000_0001);
    send_pair(ELEM_MAX, ELEM_MAX, {$urandom, $urandom}, 1'b1);
    send_pair(ELEM_MIN, ELEM_NEG_ONE, CLAIM_MIN, 1'b1);
  endtask

  // Change the modulus between two elements of one vector
  task automatic test_modulus_switch();
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    wait_idle();
    write_modulus(32'd1000003);
    send_pair(ELEM_MAX, 32'd77, CLAIM_MAX, 1'b0);
    send_pair(ELEM_MIN, 32'd3, CLAIM_MIN, 1'b0);
    wait_idle();
    write_modulus(32'd97);
    send_pair(-32'sd1234567, ELEM_MAX, '0, 1'b0);
    a = pick_elem();
    b = pick_elem();
    send_pair(a, b, congruent_claim(residue_after_pair(a, b)), 1'b1);
  endtask

  // Hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    wait_idle();
    write_modulus({1'b0, MODULUS_RESET});
    @(posedge clk_i);
    hold_off_start = 1'b1;
    @(negedge clk_i);
    repeat (6) send_single(pick_elem(), pick_elem());
  endtask

  // Random vectors over several moduli
  task automatic test_random_vectors();
    int phase_items;
    int vec_len;
    logic [PDATA_W-1:0] modulus_pick;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: modulus_pick = $urandom_range(32'h7FFF_FFFF, 1);
        1: modulus_pick = $urandom_range(64, 2);
        2: modulus_pick = {1'b0, MODULUS_RESET};
        3: modulus_pick = '0;
        4: modulus_pick = 32'h4000_0000;
        default: modulus_pick = $urandom | 32'h8000_0000;
      endcase
      wait_idle();
      write_modulus(modulus_pick);
      steady_flow = (phase == 2);
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / RANDOM_PHASES) begin
        vec_len = ($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(12, 5);
        for (int i = 1; i < vec_len; i++) begin
          send_pair(pick_elem(), pick_elem(), {$urandom, $urandom}, 1'b0);
        end
        a = pick_elem();
        b = pick_elem();
        send_pair(a, b, pick_claim(residue_after_pair(a, b)), 1'b1);
        phase_items += vec_len;
      end
    end
    steady_flow = 1'b0;
  endtask

  // Result side flow control: random stalls, steady stretch, long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_off_start) begin
      hold_off_start = 1'b0;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (steady_flow) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 36);
    end
  end

  // Compare each result transaction with the oldest expected verdict
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no verdict expected");
      end else begin
        want = verdict_q.pop_front();
        if (out_if.congruent !== want.congruent) begin
          report_mismatch($sformatf("congruent %b, expected %b",
                                    out_if.congruent, want.congruent));
        end
        if (out_if.residue !== want.residue) begin
          report_mismatch($sformatf("residue %0d, expected %0d",
                                    out_if.residue, want.residue));
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.elem_a      = '0;
    in_if.elem_b      = '0;
    in_if.claimed_sum = '0;
    in_if.last_elem   = 1'b0;
    out_if.ready      = 1'b0;
    modulus_shadow    = MODULUS_RESET;
    partial_residue   = '0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    hold_left         = 0;
    hold_off_start    = 1'b0;
    steady_flow       = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_modulus_zero();
    test_modulus_one();
    test_modulus_switch();
    test_backpressure();
    test_random_vectors();

    // Drain and settle before the verdict
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- modular_dot_product_check_core.f -----
rtl/mdpc_pkg.sv
rtl/mdpc_in_if.sv
rtl/mdpc_out_if.sv
rtl/mdpc_ctrl.sv
rtl/mdpc_datapath.sv
rtl/modular_dot_product_check_core.sv
rtl/mdpc_checker.sv
tb/tb_modular_dot_product_check_core.sv
